@@ design/pgmf_pkg.sv @@
// Shared constants and types for the prime gap mode finder.
`timescale 1ns / 1ps

package pgmf_pkg;

    localparam int MAX_N_DEFAULT   = 65536;
    localparam int MAX_GAP_DEFAULT = 128;

    localparam int RANGE_W   = 16;
    localparam int COUNT_W   = 16;
    localparam int GAP_OUT_W = 7;

    typedef struct packed {
        logic                 has_champion;
        logic [GAP_OUT_W-1:0] champion_gap;
    } result_t;

endpackage

@@ design/pgmf_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module pgmf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/pgmf_bitmap.sv @@
// Composite bitmap memory with the sieve sequencer that fills it after reset.
`timescale 1ns / 1ps

module pgmf_bitmap #(
    parameter int MAX_N = pgmf_pkg::MAX_N_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    output logic                     ready,
    input  logic                     rd_en,
    input  logic [$clog2(MAX_N)-1:0] rd_addr,
    output logic                     rd_data
);

    localparam int AW = $clog2(MAX_N);
    localparam int SW = AW + 1;

    localparam logic [2:0] S_FILL = 3'd0;
    localparam logic [2:0] S_PICK = 3'd1;
    localparam logic [2:0] S_TEST = 3'd2;
    localparam logic [2:0] S_MARK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] a_reg, a_next;
    logic [SW-1:0] i_reg, i_next;
    logic [SW-1:0] sq_reg, sq_next;
    logic [SW-1:0] j_reg, j_next;

    logic          fill_val;
    logic [SW-1:0] i_adv;
    logic [SW-1:0] sq_adv;
    logic          adv_more;
    logic [SW-1:0] j_step;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;

    // 0 and 1 are composite, as is every even number from 4 on.
    assign fill_val = (a_reg < AW'(2)) || (!a_reg[0] && (a_reg >= AW'(4)));

    // Next odd candidate; its square follows from (i + 2)^2 = i^2 + 4i + 4.
    assign i_adv    = i_reg + SW'(2);
    assign sq_adv   = sq_reg + (i_reg << 2) + SW'(4);
    assign adv_more = sq_adv < SW'(MAX_N);
    assign j_step   = j_reg + (i_reg << 1);

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        i_next     = i_reg;
        sq_next    = sq_reg;
        j_next     = j_reg;
        unique case (state_reg)
            S_FILL:
            begin
                a_next = a_reg + AW'(1);
                if (a_reg == AW'(MAX_N - 1))
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (ram_rdata)
                begin
                    i_next     = i_adv;
                    sq_next    = sq_adv;
                    state_next = adv_more ? S_PICK : S_DONE;
                end
                else
                begin
                    j_next     = sq_reg;
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                j_next = j_step;
                if (j_step >= SW'(MAX_N))
                begin
                    i_next     = i_adv;
                    sq_next    = sq_adv;
                    state_next = adv_more ? S_PICK : S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_DONE;
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL;
            a_reg     <= '0;
            i_reg     <= SW'(3);
            sq_reg    <= SW'(9);
        end
        else
        begin
            state_reg <= state_next;
            a_reg     <= a_next;
            i_reg     <= i_next;
            sq_reg    <= sq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg <= j_next;
    end

    assign ready     = (state_reg == S_DONE);
    assign ram_we    = (state_reg == S_FILL) || (state_reg == S_MARK);
    assign ram_waddr = (state_reg == S_FILL) ? a_reg : AW'(j_reg);
    assign ram_wdata = (state_reg == S_FILL) ? fill_val : 1'b1;
    assign ram_re    = ready ? rd_en : (state_reg == S_PICK);
    assign ram_raddr = ready ? rd_addr : AW'(i_reg);
    assign rd_data   = ram_rdata;

    pgmf_ram #(
        .WIDTH (1),
        .DEPTH (MAX_N)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ready |=> ready)
        else $error("bitmap left the ready state");
    a_no_write_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        ready |-> !ram_we)
        else $error("bitmap written after the sieve finished");
    a_mark_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |-> (32'(j_reg) < 32'(MAX_N)))
        else $error("sieve marks beyond the bitmap");
`endif

endmodule

@@ design/pgmf_query.sv @@
// Query engine: histogram clear, range walk with gap counting, and mode scan.
`timescale 1ns / 1ps

module pgmf_query #(
    parameter int MAX_N   = pgmf_pkg::MAX_N_DEFAULT,
    parameter int MAX_GAP = pgmf_pkg::MAX_GAP_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic [pgmf_pkg::RANGE_W-1:0]  range_low,
    input  logic [pgmf_pkg::RANGE_W-1:0]  range_high,
    output logic                          active,
    output logic                          map_rd_en,
    output logic [$clog2(MAX_N)-1:0]      map_rd_addr,
    input  logic                          map_rd_data,
    output logic                          res_valid,
    output pgmf_pkg::result_t             res
);

    import pgmf_pkg::*;

    localparam int AW = $clog2(MAX_N);
    localparam int GW = $clog2(MAX_GAP);
    localparam int VW = RANGE_W + 1;

    localparam logic [GW-1:0] LAST_BIN = GW'(MAX_GAP - 1);

    localparam logic [2:0] Q_IDLE  = 3'd0;
    localparam logic [2:0] Q_CLEAR = 3'd1;
    localparam logic [2:0] Q_WALK  = 3'd2;
    localparam logic [2:0] Q_DRAIN = 3'd3;
    localparam logic [2:0] Q_SCAN  = 3'd4;
    localparam logic [2:0] Q_WAIT  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [VW-1:0]      v_reg, v_next;
    logic [RANGE_W-1:0] hi_reg, hi_next;
    logic [GW-1:0]      k_reg, k_next;

    logic               b_valid_reg, b_valid_next;
    logic               b_inb_reg, b_inb_next;
    logic [RANGE_W-1:0] b_v_reg, b_v_next;
    logic [RANGE_W-1:0] last_reg, last_next;
    logic               last_valid_reg, last_valid_next;

    logic               c_valid_reg, c_valid_next;
    logic [GW-1:0]      c_addr_reg, c_addr_next;
    logic               w_valid_reg, w_valid_next;
    logic [GW-1:0]      w_addr_reg, w_addr_next;
    logic [COUNT_W-1:0] w_val_reg, w_val_next;

    logic               s_valid_reg, s_valid_next;
    logic [GW-1:0]      s_idx_reg, s_idx_next;
    logic [COUNT_W-1:0] best_reg, best_next;
    logic [GW-1:0]      winner_reg, winner_next;
    logic               unique_reg, unique_next;

    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;

    logic               issue;
    logic               v_inb;
    logic               b_prime;
    logic [RANGE_W-1:0] gap;
    logic               h_issue;
    logic [COUNT_W-1:0] c_cur;
    logic [COUNT_W-1:0] c_new;
    logic               scan_last;

    logic               hist_we;
    logic [GW-1:0]      hist_waddr;
    logic [COUNT_W-1:0] hist_wdata;
    logic               hist_re;
    logic [GW-1:0]      hist_raddr;
    logic [COUNT_W-1:0] hist_rdata;

    // Walk front: one bitmap lookup per cycle; numbers past the map are composite.
    assign issue       = (state_reg == Q_WALK) && (v_reg <= {1'b0, hi_reg});
    assign v_inb       = 32'(v_reg) < 32'(MAX_N);
    assign map_rd_en   = issue && v_inb;
    assign map_rd_addr = AW'(v_reg);

    // Second stage: the bitmap bit is back; a prime opens a histogram update.
    assign b_prime = b_valid_reg && b_inb_reg && !map_rd_data;
    assign gap     = b_v_reg - last_reg;
    assign h_issue = b_prime && last_valid_reg && (32'(gap) < 32'(MAX_GAP));

    // Third stage: the count is back. A write to the same bin in the previous
    // cycle is not yet in the read data, so it is forwarded.
    assign c_cur = (w_valid_reg && (w_addr_reg == c_addr_reg)) ? w_val_reg : hist_rdata;
    assign c_new = (c_cur == '1) ? c_cur : c_cur + COUNT_W'(1);

    assign scan_last = (state_reg == Q_WAIT) && s_valid_reg && (s_idx_reg == LAST_BIN);

    always_comb
    begin
        state_next      = state_reg;
        v_next          = v_reg;
        hi_next         = hi_reg;
        k_next          = k_reg;
        last_next       = last_reg;
        last_valid_next = last_valid_reg;
        best_next       = best_reg;
        winner_next     = winner_reg;
        unique_next     = unique_reg;

        if (b_prime)
        begin
            last_next       = b_v_reg;
            last_valid_next = 1'b1;
        end

        // Ascending scan: a strictly larger count takes the lead, an equal
        // count at the lead cancels the champion.
        if (s_valid_reg && (hist_rdata != '0))
        begin
            priority if (hist_rdata == best_reg)
            begin
                unique_next = 1'b0;
            end
            else if (hist_rdata > best_reg)
            begin
                best_next   = hist_rdata;
                winner_next = s_idx_reg;
                unique_next = 1'b1;
            end
        end

        unique case (state_reg)
            Q_IDLE:
            begin
                if (cmd_valid)
                begin
                    hi_next         = range_high;
                    v_next          = {1'b0, range_low};
                    k_next          = '0;
                    last_valid_next = 1'b0;
                    best_next       = '0;
                    winner_next     = '0;
                    unique_next     = 1'b0;
                    state_next      = Q_CLEAR;
                end
            end
            Q_CLEAR:
            begin
                k_next = k_reg + GW'(1);
                if (k_reg == LAST_BIN)
                begin
                    state_next = Q_WALK;
                end
            end
            Q_WALK:
            begin
                if (issue)
                begin
                    v_next = v_reg + VW'(1);
                end
                else
                begin
                    state_next = Q_DRAIN;
                end
            end
            Q_DRAIN:
            begin
                if (!b_valid_reg && !c_valid_reg)
                begin
                    k_next     = '0;
                    state_next = Q_SCAN;
                end
            end
            Q_SCAN:
            begin
                k_next = k_reg + GW'(1);
                if (k_reg == LAST_BIN)
                begin
                    state_next = Q_WAIT;
                end
            end
            Q_WAIT:
            begin
                if (scan_last)
                begin
                    state_next = Q_IDLE;
                end
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
    end

    assign b_valid_next = issue;
    assign b_inb_next   = v_inb;
    assign b_v_next     = v_reg[RANGE_W-1:0];
    assign c_valid_next = h_issue;
    assign c_addr_next  = GW'(gap);
    assign w_valid_next = c_valid_reg;
    assign w_addr_next  = c_addr_reg;
    assign w_val_next   = c_new;
    assign s_valid_next = (state_reg == Q_SCAN);
    assign s_idx_next   = k_reg;

    assign res_valid_next = scan_last;

    always_comb
    begin
        res_next = res_reg;
        if (scan_last)
        begin
            res_next.has_champion = unique_next;
            res_next.champion_gap = unique_next ? GAP_OUT_W'(winner_next) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= Q_IDLE;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            w_valid_reg    <= 1'b0;
            s_valid_reg    <= 1'b0;
            last_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            b_valid_reg    <= b_valid_next;
            c_valid_reg    <= c_valid_next;
            w_valid_reg    <= w_valid_next;
            s_valid_reg    <= s_valid_next;
            last_valid_reg <= last_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        hi_reg     <= hi_next;
        k_reg      <= k_next;
        b_inb_reg  <= b_inb_next;
        b_v_reg    <= b_v_next;
        last_reg   <= last_next;
        c_addr_reg <= c_addr_next;
        w_addr_reg <= w_addr_next;
        w_val_reg  <= w_val_next;
        s_idx_reg  <= s_idx_next;
        best_reg   <= best_next;
        winner_reg <= winner_next;
        unique_reg <= unique_next;
        res_reg    <= res_next;
    end

    assign hist_we    = (state_reg == Q_CLEAR) || c_valid_reg;
    assign hist_waddr = (state_reg == Q_CLEAR) ? k_reg : c_addr_reg;
    assign hist_wdata = (state_reg == Q_CLEAR) ? '0 : c_new;
    assign hist_re    = (state_reg == Q_SCAN) || h_issue;
    assign hist_raddr = (state_reg == Q_SCAN) ? k_reg : GW'(gap);

    pgmf_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_GAP)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    assign active    = (state_reg != Q_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |=> !res_valid_reg)
        else $error("result strobe lasted more than one cycle");
    a_update_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> ((state_reg == Q_WALK) || (state_reg == Q_DRAIN)))
        else $error("histogram update outside the walk");
    a_scan_data_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg |-> ((state_reg == Q_SCAN) || (state_reg == Q_WAIT)))
        else $error("scan data outside the scan");
`endif

endmodule

@@ design/prime_gap_mode_finder_top.sv @@
// Top level of the prime gap mode finder: command port, sieve bitmap and query engine.
`timescale 1ns / 1ps

// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------
// command  | start / busy       | range_low, range_high
// result   | done (1-cycle)     | has_champion, champion_gap
//
// A command beat is taken at a rising edge with start high and busy low.
// After reset the sieve fills the composite bitmap first: an initial fill
// of all MAX_N addresses, then the marking pass; busy stays high until it
// is done. A query runs one histogram clear pass, one bitmap lookup per
// number of the range (the single read port of the bitmap memory sets that
// pace), then one scan pass over the histogram memory. An empty range
// counts as no numbers and skips the walk.
// The result beat shows for exactly one cycle on done and cannot be held off;
// busy is already low in that cycle, so the next command may be taken there.

module prime_gap_mode_finder_top #(
    parameter int MAX_N   = pgmf_pkg::MAX_N_DEFAULT,
    parameter int MAX_GAP = pgmf_pkg::MAX_GAP_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [pgmf_pkg::RANGE_W-1:0]   range_low,
    input  logic [pgmf_pkg::RANGE_W-1:0]   range_high,
    output logic                           done,
    output logic                           has_champion,
    output logic [pgmf_pkg::GAP_OUT_W-1:0] champion_gap
);

    import pgmf_pkg::*;

    localparam int AW = $clog2(MAX_N);

    logic          map_ready;
    logic          map_rd_en;
    logic [AW-1:0] map_rd_addr;
    logic          map_rd_data;
    logic          q_active;
    logic          cmd_take;
    logic          res_valid;
    result_t       res;

    // The engine is busy while the sieve runs and while a query is in flight.
    assign busy     = !map_ready || q_active;
    assign cmd_take = start && !busy;

    pgmf_bitmap #(
        .MAX_N (MAX_N)
    ) u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .ready   (map_ready),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

    pgmf_query #(
        .MAX_N   (MAX_N),
        .MAX_GAP (MAX_GAP)
    ) u_query (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_take),
        .range_low   (range_low),
        .range_high  (range_high),
        .active      (q_active),
        .map_rd_en   (map_rd_en),
        .map_rd_addr (map_rd_addr),
        .map_rd_data (map_rd_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result registers live in the query engine; these are straight taps.
    assign done         = res_valid;
    assign has_champion = res.has_champion;
    assign champion_gap = res.champion_gap;

`ifndef SYNTHESIS
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> busy)
        else $error("engine not busy after taking a command");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a query in flight");
    a_done_frees_port: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("command port still busy with the result beat");
`endif

endmodule
